FILE: hw/rtl/bsfa_pkg.sv
// ----------------------------------------------------------------------------
// Biot-Savart accumulator package
// Shared payload types, command and register codes, widths and saturation.
// ----------------------------------------------------------------------------
package bsfa_pkg;

  localparam int COORD_FRAC_BITS_DEF = 28;
  localparam int SUM_FRAC_BITS       = 20;

  localparam int R_W     = 33;  // r = eval - seg, signed
  localparam int R2_W    = 66;  // |r|^2
  localparam int ROOT_W  = 33;  // floor(sqrt(|r|^2))
  localparam int DEN_W   = 99;  // |r|^2 * |r|
  localparam int CROSS_W = 66;  // one cross product component, signed
  localparam int MAG_W   = 65;  // its magnitude
  localparam int Q_W     = 49;  // quotient bits kept, above that is overflow
  localparam int OP_W    = 34;  // multiplier operand
  localparam int PROD_W  = 68;  // multiplier product
  localparam int EMIT_W  = 80;  // sum times current
  localparam int SMAG_W  = 60;  // magnitude handed to the saturation

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_EMIT  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] REG_EVAL_X = 2'd0;
  localparam logic [1:0] REG_EVAL_Y = 2'd1;
  localparam logic [1:0] REG_EVAL_Z = 2'd2;

  localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] seg_x;
    logic signed [31:0] seg_y;
    logic signed [31:0] seg_z;
    logic signed [31:0] dl_x;
    logic signed [31:0] dl_y;
    logic signed [31:0] dl_z;
    logic signed [31:0] coil_current;
  } bsfa_in_t;

  typedef struct packed {
    logic signed [47:0] field_x;
    logic signed [47:0] field_y;
    logic signed [47:0] field_z;
    logic               singular;
  } bsfa_out_t;

  // Returns {saturated, value}: a magnitude and a sign turned into signed
  // 48 bits, clipped at the ends of the range.
  function automatic logic [48:0] sat48(input logic [SMAG_W-1:0] mag, input logic neg);
    logic        big;
    logic [47:0] val;
    begin
      if (neg) begin
        big = (|mag[SMAG_W-1:48]) || (mag[47] && (|mag[46:0]));
        val = big ? MIN48 : (48'd0 - mag[47:0]);
      end else begin
        big = (|mag[SMAG_W-1:47]);
        val = big ? MAX48 : mag[47:0];
      end
      sat48 = {big, val};
    end
  endfunction

endpackage

FILE: hw/rtl/bsfa_sqrt.sv
// ----------------------------------------------------------------------------
// Bit-serial integer square root
// Restoring digit-by-digit root, one radicand bit pair per cycle.
// ----------------------------------------------------------------------------
module bsfa_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bsfa_pkg::R2_W-1:0]  radicand,
  output logic                       done,
  output logic [bsfa_pkg::ROOT_W-1:0] root
);
  import bsfa_pkg::*;

  localparam int REM_W = ROOT_W + 2;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [R2_W-1:0]   rad_r;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, done_r;
  logic [REM_W+1:0]  rem_sh, trial, diff;
  logic              ge;

  assign rem_sh = {rem_r, rad_r[R2_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign diff   = rem_sh - trial;
  assign ge     = (rem_sh >= trial);

  always_comb begin
    rem_nxt  = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
    root_nxt = {root_r[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ROOT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[R2_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

FILE: hw/rtl/bsfa_div.sv
// ----------------------------------------------------------------------------
// Bit-serial unsigned divider
// Restoring division, one numerator bit per cycle, with quotient overflow.
// ----------------------------------------------------------------------------
module bsfa_div #(
  parameter int NUM_W = 113,
  parameter int DEN_W = 99,
  parameter int Q_W   = 49
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [Q_W-1:0]   quo,
  output logic             ovf
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r, rem_r, rem_nxt;
  logic [Q_W-1:0]   q_r;
  logic             ovf_r, busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W:0]   rem_sh, diff;
  logic             ge;

  assign rem_sh  = {rem_r, num_r[NUM_W-1]};
  assign diff    = rem_sh - {1'b0, den_r};
  assign ge      = (rem_sh >= {1'b0, den_r});
  assign rem_nxt = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Quotient bits pushed out of the top are only remembered as overflow.
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      q_r   <= {q_r[Q_W-2:0], ge};
      ovf_r <= ovf_r | q_r[Q_W-1];
    end
  end

  assign done = done_r;
  assign quo  = q_r;
  assign ovf  = ovf_r;

endmodule

FILE: hw/rtl/biot_savart_field_accumulator.sv
// ----------------------------------------------------------------------------
// Biot-Savart field accumulator
// Sums (dl x r)/|r|^3 over segments and emits the sum scaled by a current.
// ----------------------------------------------------------------------------
// One request is handled at a time; in_ready is low while it is worked on.
// A segment request runs the square root, then the bit-serial divider once
// for each of the three axes, one numerator bit per cycle. A segment at
// zero distance skips both and sets the singular flag. An emit request can
// wait on out_ready while an earlier result is still pending; a clear
// request is done in the idle state. All products go through a single
// registered 34x34 signed multiplier.
module biot_savart_field_accumulator #(
  parameter int COORD_FRAC_BITS = bsfa_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bsfa_pkg::bsfa_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bsfa_pkg::bsfa_out_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [3:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import bsfa_pkg::*;

  localparam int SHIFT = COORD_FRAC_BITS + SUM_FRAC_BITS;
  localparam int NUM_W = MAG_W + SHIFT;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_R2     = 4'd1;
  localparam logic [3:0] ST_CHK    = 4'd2;
  localparam logic [3:0] ST_SQRT   = 4'd3;
  localparam logic [3:0] ST_DEN    = 4'd4;
  localparam logic [3:0] ST_CROSS  = 4'd5;
  localparam logic [3:0] ST_DSTART = 4'd6;
  localparam logic [3:0] ST_DIV    = 4'd7;
  localparam logic [3:0] ST_ACC    = 4'd8;
  localparam logic [3:0] ST_EMUL   = 4'd9;
  localparam logic [3:0] ST_ESAT   = 4'd10;
  localparam logic [3:0] ST_OUT    = 4'd11;

  logic [3:0]  state_r;
  logic [1:0]  cnt_r, axis_r;

  logic signed [31:0] eval_x_r, eval_y_r, eval_z_r;
  logic signed [R_W-1:0] rx_r, ry_r, rz_r;
  logic signed [31:0] dx_r, dy_r, dz_r, cur_r;
  logic [R2_W-1:0]    r2_r;
  logic [DEN_W-1:0]   d_r;
  logic signed [CROSS_W-1:0] c_r;
  logic signed [EMIT_W-1:0]  p_r;
  logic signed [47:0] sum_r [3];
  logic signed [47:0] fld_r [3];
  logic               flag_r;
  logic               out_valid_r;
  bsfa_out_t          out_r;

  logic signed [OP_W-1:0]   op_a, op_b;
  logic signed [PROD_W-1:0] mul_r;

  logic              in_fire, cfg_wr;
  logic              sqrt_start, sqrt_done, div_start, div_done, div_ovf;
  logic [ROOT_W-1:0] root;
  logic [Q_W-1:0]    quo;

  logic [CROSS_W-1:0] c_mag;
  logic [NUM_W-1:0]   div_num;
  logic [SMAG_W-1:0]  term_mag;
  logic [48:0]        term_sat;
  logic signed [48:0] sum_add;
  logic               sum_ovf;
  logic signed [47:0] sum_nxt;
  logic [EMIT_W-1:0]  p_mag;
  logic [48:0]        emit_sat;
  logic signed [47:0] sum_sel;
  logic signed [31:0] cd_a, cd_b;
  logic signed [R_W-1:0] cr_a, cr_b;
  logic               out_load;

  assign in_ready   = (state_r == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign sqrt_start = (state_r == ST_CHK) && (r2_r != '0);
  assign div_start  = (state_r == ST_DSTART);
  assign out_load   = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eval_x_r <= '0;
      eval_y_r <= '0;
      eval_z_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_EVAL_X: eval_x_r <= cfg_pwdata;
        REG_EVAL_Y: eval_y_r <= cfg_pwdata;
        REG_EVAL_Z: eval_z_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_EVAL_X: cfg_prdata = eval_x_r;
      REG_EVAL_Y: cfg_prdata = eval_y_r;
      REG_EVAL_Z: cfg_prdata = eval_z_r;
      default:    cfg_prdata = '0;
    endcase
  end

  // Cross product operands: component a is d1*r2 - d2*r1 for the axis.
  always_comb begin
    case (axis_r)
      2'd0:    begin cd_a = dy_r; cr_a = rz_r; cd_b = dz_r; cr_b = ry_r; end
      2'd1:    begin cd_a = dz_r; cr_a = rx_r; cd_b = dx_r; cr_b = rz_r; end
      default: begin cd_a = dx_r; cr_a = ry_r; cd_b = dy_r; cr_b = rx_r; end
    endcase
  end

  assign sum_sel = sum_r[axis_r];

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      ST_R2: begin
        case (cnt_r)
          2'd0:    begin op_a = OP_W'(rx_r); op_b = OP_W'(rx_r); end
          2'd1:    begin op_a = OP_W'(ry_r); op_b = OP_W'(ry_r); end
          2'd2:    begin op_a = OP_W'(rz_r); op_b = OP_W'(rz_r); end
          default: ;
        endcase
      end
      ST_DEN: begin
        op_b = {1'b0, root};
        case (cnt_r)
          2'd0:    op_a = {1'b0, r2_r[R2_W-1:ROOT_W]};
          2'd1:    op_a = {1'b0, r2_r[ROOT_W-1:0]};
          default: ;
        endcase
      end
      ST_CROSS: begin
        case (cnt_r)
          2'd0:    begin op_a = OP_W'(cd_a); op_b = OP_W'(cr_a); end
          2'd1:    begin op_a = OP_W'(cd_b); op_b = OP_W'(cr_b); end
          default: ;
        endcase
      end
      ST_EMUL: begin
        op_b = OP_W'(cur_r);
        case (cnt_r)
          2'd0:    op_a = OP_W'(signed'(sum_sel[47:24]));
          2'd1:    op_a = {10'd0, sum_sel[23:0]};
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_r <= op_a * op_b;
  end

  // Division and saturation datapath.
  assign c_mag    = c_r[CROSS_W-1] ? CROSS_W'(-c_r) : c_r;
  assign div_num  = {c_mag[MAG_W-1:0], {SHIFT{1'b0}}};
  assign term_mag = div_ovf ? '1 : SMAG_W'(quo);
  assign term_sat = sat48(term_mag, c_r[CROSS_W-1]);
  assign sum_add  = 49'(sum_sel) + 49'(signed'(term_sat[47:0]));
  assign sum_ovf  = (sum_add[48] != sum_add[47]);
  assign sum_nxt  = sum_ovf ? (sum_add[48] ? MIN48 : MAX48) : sum_add[47:0];
  assign p_mag    = p_r[EMIT_W-1] ? EMIT_W'(-p_r) : p_r;
  assign emit_sat = sat48(p_mag[SMAG_W+SUM_FRAC_BITS-1:SUM_FRAC_BITS], p_r[EMIT_W-1]);

  bsfa_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (r2_r),
    .done     (sqrt_done),
    .root     (root)
  );

  bsfa_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .Q_W   (Q_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (d_r),
    .done  (div_done),
    .quo   (quo),
    .ovf   (div_ovf)
  );

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      axis_r      <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) sum_r[i] <= '0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            cnt_r  <= '0;
            axis_r <= '0;
            case (in_data.cmd)
              CMD_ADD:  state_r <= ST_R2;
              CMD_EMIT: state_r <= ST_EMUL;
              CMD_CLEAR: begin
                flag_r <= 1'b0;
                for (int i = 0; i < 3; i++) sum_r[i] <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_R2: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 2'd3) state_r <= ST_CHK;
        end
        ST_CHK: begin
          if (r2_r == '0) begin
            flag_r  <= 1'b1;
            state_r <= ST_IDLE;
          end else begin
            state_r <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sqrt_done) begin
            cnt_r   <= '0;
            state_r <= ST_DEN;
          end
        end
        ST_DEN: begin
          if (cnt_r == 2'd2) begin
            cnt_r   <= '0;
            state_r <= ST_CROSS;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_CROSS: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 2'd2) state_r <= ST_DSTART;
        end
        ST_DSTART: state_r <= ST_DIV;
        ST_DIV: begin
          if (div_done) state_r <= ST_ACC;
        end
        ST_ACC: begin
          sum_r[axis_r] <= sum_nxt;
          if (term_sat[48] || sum_ovf) flag_r <= 1'b1;
          cnt_r <= '0;
          if (axis_r == 2'd2) begin
            state_r <= ST_IDLE;
          end else begin
            axis_r  <= axis_r + 1'b1;
            state_r <= ST_CROSS;
          end
        end
        ST_EMUL: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 2'd2) state_r <= ST_ESAT;
        end
        ST_ESAT: begin
          if (emit_sat[48]) flag_r <= 1'b1;
          cnt_r <= '0;
          if (axis_r == 2'd2) begin
            state_r <= ST_OUT;
          end else begin
            axis_r  <= axis_r + 1'b1;
            state_r <= ST_EMUL;
          end
        end
        ST_OUT: begin
          if (out_load) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rx_r  <= R_W'(eval_x_r) - R_W'(in_data.seg_x);
      ry_r  <= R_W'(eval_y_r) - R_W'(in_data.seg_y);
      rz_r  <= R_W'(eval_z_r) - R_W'(in_data.seg_z);
      dx_r  <= in_data.dl_x;
      dy_r  <= in_data.dl_y;
      dz_r  <= in_data.dl_z;
      cur_r <= in_data.coil_current;
    end
    if (state_r == ST_R2) begin
      if (cnt_r == 2'd1) r2_r <= mul_r[R2_W-1:0];
      else if (cnt_r != 2'd0) r2_r <= r2_r + mul_r[R2_W-1:0];
    end
    if (state_r == ST_DEN) begin
      if (cnt_r == 2'd1) d_r <= {mul_r[R2_W-1:0], {ROOT_W{1'b0}}};
      else if (cnt_r == 2'd2) d_r <= d_r + DEN_W'(mul_r[R2_W-1:0]);
    end
    if (state_r == ST_CROSS) begin
      if (cnt_r == 2'd1) c_r <= mul_r[CROSS_W-1:0];
      else if (cnt_r == 2'd2) c_r <= c_r - mul_r[CROSS_W-1:0];
    end
    // The signed upper half of the sum enters first and is weighted by 2^24.
    if (state_r == ST_EMUL) begin
      if (cnt_r == 2'd1) p_r <= EMIT_W'(mul_r) <<< 24;
      else if (cnt_r == 2'd2) p_r <= p_r + EMIT_W'(mul_r);
    end
    if (state_r == ST_ESAT) fld_r[axis_r] <= emit_sat[47:0];
    if (out_load) begin
      out_r.field_x  <= fld_r[0];
      out_r.field_y  <= fld_r[1];
      out_r.field_z  <= fld_r[2];
      out_r.singular <= flag_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The divider only ever sees a nonzero denominator.
  a_div_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (d_r != '0))
    else $error("divider started with a zero denominator");

  // The root is the floor of the square root of the squared distance.
  a_sqrt_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (sqrt_done && state_r == ST_SQRT) |->
      ((R2_W'(root) * R2_W'(root) <= r2_r) &&
       (68'(root + 34'd1) * 68'(root + 34'd1) > 68'(r2_r))))
    else $error("square root result out of range");

  // A clear request leaves the sums and the flag at zero.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.cmd == CMD_CLEAR) |=>
      (!flag_r && sum_r[0] == '0 && sum_r[1] == '0 && sum_r[2] == '0))
    else $error("clear request did not clear the accumulator");

  // A result is only loaded once the previous one has been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (state_r == ST_OUT || $stable(out_r)))
    else $error("pending result overwritten");

endmodule
